// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
    localparam logic [20:0] MIN_CP_LEN2    = 21'h000080;
    localparam logic [20:0] MIN_CP_LEN3    = 21'h000800;
    localparam logic [20:0] MIN_CP_LEN4    = 21'h010000;
    localparam logic [15:0] CP437_DEL_CP   = 16'h2302;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam logic [15:0] CP437_CTRL [32] = '{
        16'h0020, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
        16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
    };

    localparam logic [15:0] CP437_UPPER [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_last;
    } in_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic        run_last;
        logic        line_end;
        logic        line_valid;
    } out_item_t;

    // One accepted byte's worth of results: rep_count replacements, then
    // optionally one decoded code point.
    typedef struct packed {
        logic [2:0]  rep_count;
        logic        has_cp;
        logic [20:0] code_point;
        logic        line_last;
        logic        line_valid;
    } desc_t;

    function automatic logic [15:0] cp437_map(input logic [7:0] b);
        logic [15:0] r;
        priority if (b < 8'h20)
            r = CP437_CTRL[b[4:0]];
        else if (b < 8'h7F)
            r = {8'h00, b};
        else if (b == 8'h7F)
            r = CP437_DEL_CP;
        else
            r = CP437_UPPER[b[6:0]];
        return r;
    endfunction

endpackage

// ===== rtl/u8d_front.sv =====
module u8d_front
    import u8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_data,
    input  logic     in_valid,
    input  in_item_t in_item,
    input  logic     full,
    output logic     push,
    output desc_t    push_desc
);

    logic        mode_reg;
    logic [1:0]  pend_reg, pend_next;
    logic [2:0]  elen_reg, elen_next;
    logic [14:0] acc_reg, acc_next;
    logic        line_error_reg, line_error_next;

    logic        in_fire;
    logic [7:0]  b;
    logic        last;
    logic        is_cont, is_ascii, is_lead2, is_lead3, is_lead4;
    logic [20:0] cpn;
    logic [2:0]  taken;
    logic        seq_bad;
    logic [2:0]  rep_count;
    logic        has_cp;
    logic [20:0] cp;

    assign in_fire  = in_valid && !full;
    assign b        = in_item.in_byte;
    assign last     = in_item.line_last;
    assign is_cont  = (b[7:6] == 2'b10);
    assign is_ascii = !b[7];
    assign is_lead2 = (b[7:5] == 3'b110);
    assign is_lead3 = (b[7:4] == 4'b1110);
    assign is_lead4 = (b[7:3] == 5'b11110);
    assign cpn      = {acc_reg, b[5:0]};
    assign taken    = {1'b0, pend_reg} + 3'd1;

    assign seq_bad = ((elen_reg == SEQ_LEN2) && (cpn < MIN_CP_LEN2)) ||
                     ((elen_reg == SEQ_LEN3) && (cpn < MIN_CP_LEN3)) ||
                     ((elen_reg == SEQ_LEN4) && (cpn < MIN_CP_LEN4)) ||
                     ((cpn >= SURROGATE_LO) && (cpn <= SURROGATE_HI));

    always_comb
    begin
        rep_count = 3'd0;
        has_cp    = 1'b0;
        cp        = '0;
        pend_next = pend_reg;
        elen_next = elen_reg;
        acc_next  = acc_reg;
        if (mode_reg)
        begin
            has_cp = 1'b1;
            cp     = {5'd0, cp437_map(b)};
        end
        else if ((pend_reg != 2'd0) && is_cont)
        begin
            pend_next = 2'd0;
            elen_next = 3'd0;
            acc_next  = '0;
            if (taken < elen_reg)
            begin
                // Line ends inside the sequence: drop it, one FFFD per byte.
                if (last)
                    rep_count = taken;
                else
                begin
                    pend_next = taken[1:0];
                    elen_next = elen_reg;
                    acc_next  = cpn[14:0];
                end
            end
            else if (seq_bad)
                rep_count = taken;
            else
            begin
                has_cp = 1'b1;
                cp     = cpn;
            end
        end
        else
        begin
            // Flush any broken sequence, then decode the byte afresh.
            pend_next = 2'd0;
            elen_next = 3'd0;
            acc_next  = '0;
            rep_count = {1'b0, pend_reg};
            priority if (is_ascii)
            begin
                has_cp = 1'b1;
                cp     = {13'd0, b};
            end
            else if (is_lead2 || is_lead3 || is_lead4)
            begin
                if (last)
                    rep_count = {1'b0, pend_reg} + 3'd1;
                else
                begin
                    pend_next = 2'd1;
                    priority if (is_lead2)
                    begin
                        elen_next = SEQ_LEN2;
                        acc_next  = {10'd0, b[4:0]};
                    end
                    else if (is_lead3)
                    begin
                        elen_next = SEQ_LEN3;
                        acc_next  = {11'd0, b[3:0]};
                    end
                    else
                    begin
                        elen_next = SEQ_LEN4;
                        acc_next  = {12'd0, b[2:0]};
                    end
                end
            end
            else
                rep_count = {1'b0, pend_reg} + 3'd1;
        end
        line_error_next = last ? 1'b0 : (line_error_reg || (rep_count != 3'd0));
    end

    assign push                 = in_fire && ((rep_count != 3'd0) || has_cp);
    assign push_desc.rep_count  = rep_count;
    assign push_desc.has_cp     = has_cp;
    assign push_desc.code_point = cp;
    assign push_desc.line_last  = last;
    assign push_desc.line_valid = !(line_error_reg || (rep_count != 3'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            pend_reg       <= 2'd0;
            elen_reg       <= 3'd0;
            acc_reg        <= '0;
            line_error_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            // Mode change drops any open sequence but keeps the line error.
            mode_reg <= cfg_data;
            pend_reg <= 2'd0;
            elen_reg <= 3'd0;
            acc_reg  <= '0;
        end
        else if (in_fire)
        begin
            pend_reg       <= pend_next;
            elen_reg       <= elen_next;
            acc_reg        <= acc_next;
            line_error_reg <= line_error_next;
        end
    end

    a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd0) |-> ({1'b0, pend_reg} < elen_reg))
        else $error("open sequence holds as many bytes as its length");

endmodule

// ===== rtl/u8d_queue.sv =====
module u8d_queue
    import u8d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output desc_t head
);

    desc_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CW'(1);
            2'b01:   count_next = count_reg - QUEUE_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("request written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("request taken from an empty queue");

endmodule

// ===== rtl/u8d_back.sv =====
module u8d_back
    import u8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  desc_t     head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic      cur_busy_reg, cur_busy_next;
    desc_t     cur_reg, cur_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    desc_t     act;
    logic      act_valid;
    logic      out_free;
    logic      fire;
    logic      rep_nz;
    logic      final_res;

    // Work on the held request if one is partly sent, else straight from the queue.
    assign act       = cur_busy_reg ? cur_reg : head;
    assign act_valid = cur_busy_reg || head_valid;
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = act_valid && out_free;
    assign pop       = fire && !cur_busy_reg;
    assign rep_nz    = (act.rep_count != 3'd0);
    assign final_res = !rep_nz || ((act.rep_count == 3'd1) && !act.has_cp);

    always_comb
    begin
        out_item_next.code_point = rep_nz ? REPLACEMENT_CP : act.code_point;
        out_item_next.replaced   = rep_nz;
        out_item_next.run_last   = final_res;
        out_item_next.line_end   = final_res && act.line_last;
        out_item_next.line_valid = final_res && act.line_last && act.line_valid;

        cur_next           = act;
        cur_next.rep_count = rep_nz ? (act.rep_count - 3'd1) : act.rep_count;
        cur_busy_next      = cur_busy_reg;
        out_valid_next     = out_valid_reg;
        if (out_free)
            out_valid_next = fire;
        if (fire)
            cur_busy_next = !final_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_busy_reg  <= cur_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cur_reg      <= cur_next;
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_busy_reg |-> ((cur_reg.rep_count != 3'd0) || cur_reg.has_cp))
        else $error("held request has nothing left to send");

    a_line_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.line_end) |-> out_item_reg.run_last)
        else $error("line end on a result that is not the last of its byte");

    a_busy_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !final_res) |=> (cur_busy_reg && !pop))
        else $error("queue advanced while a request was partly sent");

endmodule

// ===== rtl/utf8_validating_decoder_unit.sv =====
// UTF-8 decoder with replacement and a code page 437 mode.
// Input channel: in_valid/in_stall with in_item (one text byte plus a flag for
// the last byte of a line). Output channel: out_valid/out_stall with out_item
// (code point, replaced, run_last, line_end, line_valid).
// Config: cfg_we writes cfg_data into the decode mode (0 UTF-8, 1 CP437) and
// drops any open UTF-8 sequence; write it only while the block is idle.
// Each byte gives zero to four results. A byte is accepted when the request
// queue (four entries) has room; its results pass through the queue and then
// the registered output, where the receiver takes them.
// While out_stall is low the output side sends one result per cycle, so the
// sustained rate is one byte per cycle while bytes give at most one result
// each; a byte that gives n results holds the output side until all are sent
// and the queue absorbs the burst. in_stall rises only when the queue is full.
// When the receiver stalls, the output register holds its result, the queue
// fills, and then the input stalls.
// Reset clears the queue, the output register, any open sequence, the line
// error flag and sets UTF-8 mode.
module utf8_validating_decoder_unit
    import u8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic  push;
    desc_t push_desc;
    logic  pop;
    logic  full;
    logic  head_valid;
    desc_t head;

    assign in_stall = full;

    u8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .full      (full),
        .push      (push),
        .push_desc (push_desc)
    );

    u8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// ===== sim/utf8_decode_checker.sv =====
module utf8_decode_checker
    import u8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    output int        backlog,
    output int        fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] FLOOR_LEN2   = 21'h000080;
    localparam logic [20:0] FLOOR_LEN3   = 21'h000800;
    localparam logic [20:0] FLOOR_LEN4   = 21'h010000;
    localparam logic [20:0] DEL_GLYPH    = 21'h002302;
    localparam logic [2:0]  LEN_TWO      = 3'd2;
    localparam logic [2:0]  LEN_THREE    = 3'd3;
    localparam logic [2:0]  LEN_FOUR     = 3'd4;
    localparam logic        MODE_CP437   = 1'b1;

    localparam logic [15:0] GLYPH_CTRL [32] = '{
        16'h0020, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
        16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
    };

    localparam logic [15:0] GLYPH_HIGH [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // decoder state as the block should hold it
    logic        mode;
    logic [1:0]  seq_taken;
    logic [2:0]  seq_len;
    logic [20:0] accum;
    logic        line_bad;

    // code points produced by the request being decoded
    logic [20:0] step_cp [4];
    logic        step_rep [4];
    int          step_n;

    out_item_t   code_points_due [$];

    task automatic emit_cp(input logic [20:0] cp, input logic rep);
        if (step_n < 4)
        begin
            step_cp[step_n] = cp;
            step_rep[step_n] = rep;
            step_n++;
        end
    endtask

    task automatic drop_sequence();
        seq_taken = 2'd0;
        seq_len = 3'd0;
        accum = 21'd0;
    endtask

    // one replacement per byte already gathered
    task automatic flush_open();
        int k;
        for (k = 0; k < int'(seq_taken); k++)
            emit_cp(REPLACEMENT, 1'b1);
        drop_sequence();
    endtask

    task automatic decode_request(input in_item_t req);
        logic [7:0]  b;
        logic [20:0] cp;
        logic        fresh;
        logic        bad;
        logic        any_rep;
        int          k;
        out_item_t   r;
        b = req.in_byte;
        fresh = 1'b0;
        any_rep = 1'b0;
        step_n = 0;
        if (mode == MODE_CP437)
        begin
            if (b < 8'h20)
                emit_cp({5'd0, GLYPH_CTRL[b[4:0]]}, 1'b0);
            else if (b < 8'h7F)
                emit_cp({13'd0, b}, 1'b0);
            else if (b == 8'h7F)
                emit_cp(DEL_GLYPH, 1'b0);
            else
                emit_cp({5'd0, GLYPH_HIGH[b[6:0]]}, 1'b0);
        end
        else
        begin
            if (seq_taken == 2'd0)
                fresh = 1'b1;
            else if (b[7:6] != 2'b10)
            begin
                // broken sequence: replace what was gathered, then retry this byte
                flush_open();
                fresh = 1'b1;
            end
            else
            begin
                cp = {accum[14:0], b[5:0]};
                if (int'(seq_taken) + 1 < int'(seq_len))
                begin
                    accum = cp;
                    seq_taken = seq_taken + 2'd1;
                end
                else
                begin
                    bad = (seq_len == LEN_TWO && cp < FLOOR_LEN2) ||
                          (seq_len == LEN_THREE && cp < FLOOR_LEN3) ||
                          (seq_len == LEN_FOUR && cp < FLOOR_LEN4) ||
                          (cp >= SURR_FIRST && cp <= SURR_LAST);
                    if (bad)
                    begin
                        for (k = 0; k <= int'(seq_taken); k++)
                            emit_cp(REPLACEMENT, 1'b1);
                    end
                    else
                        emit_cp(cp, 1'b0);
                    drop_sequence();
                end
            end
            if (fresh)
            begin
                if (!b[7])
                    emit_cp({13'd0, b}, 1'b0);
                else if (b[7:5] == 3'b110)
                begin
                    seq_taken = 2'd1;
                    seq_len = LEN_TWO;
                    accum = {16'd0, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_taken = 2'd1;
                    seq_len = LEN_THREE;
                    accum = {17'd0, b[3:0]};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    seq_taken = 2'd1;
                    seq_len = LEN_FOUR;
                    accum = {18'd0, b[2:0]};
                end
                else
                    emit_cp(REPLACEMENT, 1'b1);
            end
            if (req.line_last && seq_taken != 2'd0)
                flush_open();
        end

        for (k = 0; k < step_n; k++)
            any_rep = any_rep | step_rep[k];
        if (any_rep)
            line_bad = 1'b1;
        for (k = 0; k < step_n; k++)
        begin
            r.code_point = step_cp[k];
            r.replaced   = step_rep[k];
            r.run_last   = (k == step_n - 1);
            r.line_end   = (k == step_n - 1) && req.line_last;
            r.line_valid = r.line_end && !line_bad;
            code_points_due = {code_points_due, r};
        end
        if (req.line_last)
            line_bad = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [20:0] want,
                               input logic [20:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            mode = 1'b0;
            drop_sequence();
            line_bad = 1'b0;
            code_points_due.delete();
            backlog = 0;
            fail_count = 0;
        end
        else
        begin
            // a mode write drops any open sequence but keeps the line error
            if (cfg_we)
            begin
                mode = cfg_data;
                drop_sequence();
            end
            if (in_valid && !in_stall)
                decode_request(in_item);
            if (out_valid && !out_stall)
            begin
                if (code_points_due.size() == 0)
                begin
                    $error("code_point: expected none, got %h", out_item.code_point);
                    fail_count++;
                end
                else
                begin
                    want = code_points_due.pop_front();
                    check_field("code_point", want.code_point, out_item.code_point);
                    check_field("replaced", 21'(want.replaced), 21'(out_item.replaced));
                    check_field("run_last", 21'(want.run_last), 21'(out_item.run_last));
                    check_field("line_end", 21'(want.line_end), 21'(out_item.line_end));
                    check_field("line_valid", 21'(want.line_valid),
                                21'(out_item.line_valid));
                end
            end
            backlog = code_points_due.size();
        end
    end

endmodule

// ===== sim/tb_utf8_validating_decoder_unit.sv =====
module tb_utf8_validating_decoder_unit;
    import u8d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES  = 200000;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 20;
    localparam int  HOLD_CYCLES   = 80;
    localparam logic MODE_UTF8    = 1'b0;
    localparam logic MODE_CP437   = 1'b1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_data = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    int        backlog;
    int        mismatches;
    int        sent_count = 0;
    int        cycle_count = 0;
    logic      quiet = 1'b0;
    logic      hold_go = 1'b0;

    utf8_validating_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    utf8_decode_checker decode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .backlog    (backlog),
        .fail_count (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off when asked
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= {b, last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_text(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 11) == 0);
    endtask

    // encode a scalar of the given length and send its first keep bytes
    task automatic send_scalar(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] seq [4];
        int i;
        case (len)
            2: seq[0] = {3'b110, cp[10:6]};
            3: seq[0] = {4'b1110, cp[15:12]};
            default: seq[0] = {5'b11110, cp[20:18]};
        endcase
        for (i = 1; i < len; i++)
            seq[i] = {2'b10, cp[6 * (len - 1 - i) +: 6]};
        for (i = 0; i < keep; i++)
            send_text(seq[i]);
    endtask

    task automatic send_random_char();
        int pick;
        int len;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_text(8'($urandom_range(0, 8'h7F)));
        else if (pick < 50)
            send_scalar(21'($urandom_range(21'h80, 21'h7FF)), 2, 2);
        else if (pick < 65)
        begin
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
            // move surrogates up into F800..FFFF
            if (cp >= 21'hD800 && cp <= 21'hDFFF)
                cp = cp ^ 21'h2000;
            send_scalar(cp, 3, 3);
        end
        else if (pick < 75)
            send_scalar(21'($urandom_range(21'h10000, 21'h1FFFFF)), 4, 4);
        else if (pick < 80)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2: cp = 21'($urandom_range(0, 21'h7F));
                3: cp = 21'($urandom_range(0, 21'h7FF));
                default: cp = 21'($urandom_range(0, 21'hFFFF));
            endcase
            send_scalar(cp, len, len);
        end
        else if (pick < 85)
            send_scalar(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3);
        else if (pick < 93)
        begin
            len = $urandom_range(2, 4);
            send_scalar(21'($urandom()), len, $urandom_range(1, len - 1));
        end
        else if ($urandom_range(0, 1))
            send_text(8'($urandom_range(8'h80, 8'hBF)));
        else
            send_text(8'($urandom_range(8'hF8, 8'hFF)));
    endtask

    // write the mode only once every result is out and the pipe has settled
    task automatic set_mode(input logic m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII extremes, a clean line
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        // largest scalar a four-byte form can carry
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // overlong, then surrogate
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // stray byte
        send_byte(8'hFF, 1'b1);
        // broken by ASCII, then broken by a stray at line end
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // lead byte left open at line end
        send_byte(8'hC3, 1'b1);
        // mode write drops the open lead, line error survives it
        send_byte(8'h80, 1'b0);
        send_byte(8'hE2, 1'b0);
        set_mode(MODE_UTF8);
        send_byte(8'h41, 1'b1);

        set_mode(MODE_CP437);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_mode(MODE_UTF8);

        while (sent_count < 200)
        begin
            if (sent_count >= 70)
                hold_go = 1'b1;
            quiet = (sent_count >= 110 && sent_count < 170);
            send_random_char();
        end
        quiet = 1'b0;

        set_mode(MODE_CP437);
        while (sent_count < 280)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);

        set_mode(MODE_UTF8);
        while (sent_count < 410)
            send_random_char();

        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
